@@ hw/rtl/fmdb_pkg.sv @@
// package for the deduplicating fifo queue
// holds default sizes, transaction codes and the cell control struct; no dependencies
`default_nettype none

package fmdb_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_DUP_MOVED  = 2'd1;
    localparam logic [1:0] ST_FULL       = 2'd2;
    localparam logic [1:0] ST_EMPTY      = 2'd3;

    // broadcast control from the top level to every cell, decided after the match search
    typedef struct packed {
        logic dup;     // pushed value is already stored
        logic append;  // pushed value goes to the free cell at the back
        logic pop;     // front entry is removed
    } fmdb_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/fmdb_cell.sv @@
// one storage cell of the deduplicating fifo queue
// depends on fmdb_pkg for the control struct
`default_nettype none

module fmdb_cell #(
    parameter int INDEX      = 0,
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire                             clk,
    input  wire                             push,
    input  wire fmdb_pkg::fmdb_ctl_t        ctl,
    input  wire [$clog2(CAPACITY+1)-1:0]    occ,
    input  wire [DATA_WIDTH-1:0]            v,
    input  wire [DATA_WIDTH-1:0]            right_data,
    input  wire                             hit_in,
    output logic                            hit_out,
    output logic [DATA_WIDTH-1:0]           data,
    output logic [DATA_WIDTH-1:0]           data_upd
);
    import fmdb_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] IDX = CW'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic [CW-1:0]         occ_m1;
    logic                  in_use;
    logic                  hit;
    logic                  shift;

    always_comb
    begin
        in_use  = IDX < occ;
        hit     = push && in_use && (data_reg == v);
        hit_out = hit_in | hit;
    end

    always_comb
    begin
        occ_m1  = occ - CW'(1);
        // pop, or from the match on: cells up to the back take right neighbor
        shift   = (ctl.pop || (ctl.dup && hit_out)) && (IDX < occ_m1);
        if (shift)
        begin
            data_next = right_data;
        end
        else if ((ctl.dup && IDX == occ_m1) || (ctl.append && IDX == occ))
        begin
            data_next = v;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign data_upd = data_next;

endmodule

`default_nettype wire

@@ hw/rtl/fifo_move_duplicate_to_back_core.sv @@
// top level of the deduplicating fifo queue: a row of fmdb_cell storage cells,
// the occupancy counter and the registered result stage; depends on fmdb_pkg
`default_nettype none

// Deduplicating FIFO: one push or pop transaction is taken per clock cycle and its
// result appears in the output register on the next cycle; a new transaction is
// taken while that result waits, as long as the result is taken in the same cycle.
// A push compares its value against all cells at once and a match found anywhere
// ripples through the row of cells, which sets the cycle time; the matching entry
// is taken out, later entries move one cell toward the front and the value goes to
// the back, even when full. No clearing pass is run after reset.
module fifo_move_duplicate_to_back_core #(
    parameter int CAPACITY   = fmdb_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = fmdb_pkg::DATA_WIDTH_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire         mode,
    input  wire  [31:0] value,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [1:0]  status,
    output logic [31:0] popped_value,
    output logic [4:0]  entry_count,
    output logic [31:0] front_value,
    output logic [31:0] back_value
);
    import fmdb_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]         occ_reg;
    logic [CW-1:0]         occ_next;
    logic [DATA_WIDTH-1:0] back_reg;
    logic [DATA_WIDTH-1:0] back_next;

    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [1:0]  status_next;
    logic [31:0] popped_reg;
    logic [31:0] popped_next;
    logic [4:0]  count_reg;
    logic [31:0] front_reg;
    logic [31:0] front_next;
    logic [31:0] back_out_reg;
    logic [31:0] back_out_next;

    logic                  accept;
    logic                  push;
    logic                  found;
    logic                  full;
    logic                  empty;
    logic [DATA_WIDTH-1:0] v;
    fmdb_ctl_t             ctl;

    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_upd  [CAPACITY];
    logic                  chain     [CAPACITY+1];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign push     = accept && (mode == MODE_PUSH);
    assign v        = DATA_WIDTH'(value);
    assign full     = occ_reg == CW'(CAPACITY);
    assign empty    = occ_reg == '0;
    assign chain[0] = 1'b0;
    assign found    = chain[CAPACITY];

    always_comb
    begin
        ctl.dup    = push && found;
        ctl.append = push && !found && !full;
        ctl.pop    = accept && (mode == MODE_POP) && !empty;
    end

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] right;
            if (i == CAPACITY - 1)
            begin : g_last
                assign right = '0;
            end
            else
            begin : g_mid
                assign right = cell_data[i+1];
            end
            fmdb_cell #(
                .INDEX      (i),
                .CAPACITY   (CAPACITY),
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk        (clk),
                .push       (push),
                .ctl        (ctl),
                .occ        (occ_reg),
                .v          (v),
                .right_data (right),
                .hit_in     (chain[i]),
                .hit_out    (chain[i+1]),
                .data       (cell_data[i]),
                .data_upd   (cell_upd[i])
            );
        end
    endgenerate

    always_comb
    begin
        occ_next  = occ_reg;
        back_next = back_reg;
        if (ctl.append)
        begin
            occ_next = occ_reg + CW'(1);
        end
        else if (ctl.pop)
        begin
            occ_next = occ_reg - CW'(1);
        end
        // the back entry only changes when a value is pushed or moved to the back
        if (ctl.append || ctl.dup)
        begin
            back_next = v;
        end

        if (mode == MODE_PUSH)
        begin
            if (found)
            begin
                status_next = ST_DUP_MOVED;
            end
            else if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_OK;
            end
        end
        else
        begin
            status_next = empty ? ST_EMPTY : ST_OK;
        end

        popped_next   = ctl.pop ? 32'(cell_data[0]) : 32'd0;
        front_next    = (occ_next == '0) ? 32'd0 : 32'(cell_upd[0]);
        back_out_next = (occ_next == '0) ? 32'd0 : 32'(back_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        back_reg <= back_next;
        if (accept)
        begin
            status_reg   <= status_next;
            popped_reg   <= popped_next;
            count_reg    <= 5'(occ_next);
            front_reg    <= front_next;
            back_out_reg <= back_out_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign entry_count  = count_reg;
    assign front_value  = front_reg;
    assign back_value   = back_out_reg;

endmodule

`default_nettype wire

@@ test/fifo_move_duplicate_to_back_core_tb.sv @@
// testbench for fifo_move_duplicate_to_back_core: directed and random push/pop traffic
// checked against a queue-based model of the deduplicating fifo; depends on fmdb_pkg
`timescale 1ns / 100ps

module fifo_move_duplicate_to_back_core_tb;

    import fmdb_pkg::*;

    localparam int QUEUE_DEPTH = CAPACITY_DEF;
    localparam int POOL_SIZE   = 20;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] popped;
        logic [4:0]  count;
        logic [31:0] front;
        logic [31:0] back;
    } queue_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        mode;
    logic [31:0] value;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [31:0] popped_value;
    logic [4:0]  entry_count;
    logic [31:0] front_value;
    logic [31:0] back_value;

    // model contents, oldest first
    logic [31:0]   held_q[$];
    queue_result_t pending_results[$];
    logic [31:0]   value_pool[POOL_SIZE];

    int cycles;
    int n_mismatch;
    int n_accepted;
    int n_checked;
    int n_appended;
    int n_moved;
    int n_full;
    int n_empty;
    int n_popped;
    int hold_req;

    fifo_move_duplicate_to_back_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .popped_value (popped_value),
        .entry_count  (entry_count),
        .front_value  (front_value),
        .back_value   (back_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still outstanding",
                     cycles, pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // apply one transaction to the model and return the result it should produce
    function automatic queue_result_t apply_to_model(input logic m, input logic [31:0] v);
        queue_result_t r;
        int            hit;
        r   = '0;
        hit = -1;
        if (m == MODE_PUSH)
        begin
            foreach (held_q[i])
            begin
                if (hit < 0 && held_q[i] == v)
                    hit = i;
            end
            if (hit >= 0)
            begin
                held_q.delete(hit);
                held_q.push_back(v);
                r.status = ST_DUP_MOVED;
            end
            else if (held_q.size() >= QUEUE_DEPTH)
                r.status = ST_FULL;
            else
            begin
                held_q.push_back(v);
                r.status = ST_OK;
            end
        end
        else if (held_q.size() == 0)
            r.status = ST_EMPTY;
        else
        begin
            r.popped = held_q.pop_front();
            r.status = ST_OK;
        end
        r.count = 5'(held_q.size());
        if (held_q.size() != 0)
        begin
            r.front = held_q[0];
            r.back  = held_q[held_q.size() - 1];
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("error at cycle %0d: %s expected %h got %h", cycles, name, want, got);
        end
    endtask

    // result side first, then the new transaction, since a result is never same-cycle
    always @(posedge clk)
    begin
        queue_result_t want;
        queue_result_t predicted;
        if (rst_n)
        begin
            if (out_valid === 1'b1 && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("error at cycle %0d: result with nothing outstanding", cycles);
                end
                else
                begin
                    want = pending_results.pop_front();
                    n_checked++;
                    compare_field("status", 32'(want.status), 32'(status));
                    compare_field("popped_value", want.popped, popped_value);
                    compare_field("entry_count", 32'(want.count), 32'(entry_count));
                    compare_field("front_value", want.front, front_value);
                    compare_field("back_value", want.back, back_value);
                end
            end
            if (in_valid && in_ready === 1'b1)
            begin
                predicted = apply_to_model(mode, value);
                pending_results.push_back(predicted);
                n_accepted++;
                case (predicted.status)
                    ST_DUP_MOVED: n_moved++;
                    ST_FULL:      n_full++;
                    ST_EMPTY:     n_empty++;
                    default:
                    begin
                        if (mode == MODE_POP)
                            n_popped++;
                        else
                            n_appended++;
                    end
                endcase
            end
        end
    end

    // receiver: changing stall styles, plus a long hold when a test asks for one
    initial
    begin
        int style;
        int style_left;
        int tick;
        int hold_left;
        style      = 0;
        style_left = 0;
        tick       = 0;
        hold_left  = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (style_left == 0)
                begin
                    style      = $urandom_range(0, 3);
                    style_left = $urandom_range(10, 80);
                end
                style_left--;
                case (style)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ready <= ($urandom_range(0, 9) < 3);
                    default: out_ready <= (tick % 5 != 4);
                endcase
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance, valid left high
    task automatic send_op(input logic m, input logic [31:0] v);
        in_valid <= 1'b1;
        mode     <= m;
        value    <= v;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic refresh_pool();
        foreach (value_pool[i])
        begin
            case ($urandom_range(0, 15))
                0:       value_pool[i] = 32'h0000_0000;
                1:       value_pool[i] = 32'hFFFF_FFFF;
                default: value_pool[i] = $urandom;
            endcase
        end
    endtask

    // mostly values from a small pool so duplicates and a full queue come up often
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            7:       v = $urandom;
            8:       v = 32'h1 << $urandom_range(0, 31);
            9:       v = ~(32'h1 << $urandom_range(0, 31));
            default: v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
        endcase
        return v;
    endfunction

    task automatic send_random_op(input int push_pct);
        if ($urandom_range(0, 99) < push_pct)
            send_op(MODE_PUSH, pick_value());
        else
            send_op(MODE_POP, $urandom);
    endtask

    task automatic test_directed_edges();
        logic [31:0] fill_v;
        send_op(MODE_POP, 32'hDEAD_BEEF);          // pop from empty
        send_op(MODE_PUSH, 32'h0000_0000);
        send_op(MODE_PUSH, 32'hFFFF_FFFF);
        send_op(MODE_PUSH, 32'h0000_0000);         // duplicate at the front
        send_op(MODE_PUSH, 32'h0000_0000);         // duplicate already at the back
        send_op(MODE_POP, 32'h0000_0000);
        for (int k = 0; k < QUEUE_DEPTH - 1; k++)
        begin
            fill_v = (k % 2 == 0) ? (32'h8000_0000 >> k) : ~(32'h1 << k);
            send_op(MODE_PUSH, fill_v);
        end
        send_op(MODE_PUSH, 32'h5A5A_A5A5);         // new value while full is refused
        send_op(MODE_PUSH, 32'h8000_0000 >> 6);    // duplicate in the middle while full
        send_op(MODE_PUSH, 32'h0000_0000);         // front entry while full
        send_op(MODE_POP, 32'hFFFF_FFFF);
    endtask

    task automatic test_random_traffic(input int n_items);
        int sent;
        int burst;
        int push_pct;
        sent     = 0;
        push_pct = 65;
        refresh_pool();
        while (sent < n_items)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       push_pct = 90;
                    1:       push_pct = 65;
                    2:       push_pct = 45;
                    default: push_pct = 20;
                endcase
                if ($urandom_range(0, 1) == 0)
                    refresh_pool();
            end
            burst = $urandom_range(1, 24);
            repeat (burst)
            begin
                send_random_op(push_pct);
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 6));
        end
    endtask

    task automatic test_output_backpressure();
        hold_req = 120;
        repeat (40) send_random_op(70);
    endtask

    task automatic test_pause_and_drain();
        repeat (30) send_random_op(60);
        wait_for_drain();
        repeat (20) send_op(MODE_POP, $urandom);
        repeat (20) send_op(MODE_PUSH, $urandom);
        wait_for_drain();
    endtask

    initial
    begin
        cycles     = 0;
        n_mismatch = 0;
        n_accepted = 0;
        n_checked  = 0;
        n_appended = 0;
        n_moved    = 0;
        n_full     = 0;
        n_empty    = 0;
        n_popped   = 0;
        hold_req   = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        mode       = MODE_PUSH;
        value      = 32'h0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_edges();
        test_random_traffic(800);
        test_output_backpressure();
        test_pause_and_drain();
        test_random_traffic(850);

        wait_for_drain();
        repeat (10) @(negedge clk);

        $display("%0d transactions checked: %0d appended, %0d popped, %0d duplicates moved",
                 n_checked, n_appended, n_popped, n_moved);
        $display("%0d pushes refused on full, %0d pops refused on empty, %0d field errors",
                 n_full, n_empty, n_mismatch);
        if (n_mismatch == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
